// ===== hdl/hough_line_backprojector_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef HOUGH_LINE_BACKPROJECTOR_TOP_MACROS_SVH
`define HOUGH_LINE_BACKPROJECTOR_TOP_MACROS_SVH

// Immediate implication, gated by reset.
`define HLB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hlb check failed");

// Next-cycle implication, gated by reset.
`define HLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hlb check failed");

// Next-cycle implication that also covers reset.
`define HLB_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hlb check failed");

`endif

// ===== hdl/hlb_pkg.sv =====
package hlb_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int DIM_W        = 13;
  localparam int ACC_W        = 48;
  localparam int DVD_W        = 43;
  localparam logic [5:0] DIV_STEPS = 6'd43;
  localparam logic [15:0] SIN_LIMIT = 16'd23171;
  localparam logic [8:0] SIZE_RESET = 9'd256;

  localparam logic [1:0] ACT_PROJECT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PROJ,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               by_col;
    logic signed [47:0] slope;
    logic signed [47:0] offset;
    logic [15:0]        weight;
    logic [7:0]         rrow;
    logic [7:0]         rcol;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_A,
    F_DIV_B,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_WALK,
    B_DRAIN,
    B_READ,
    B_CLEAR
  } back_state_t;

endpackage

// ===== hdl/hlb_front.sv =====
module hlb_front #(
  parameter int MAX_ROWS = hlb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hlb_pkg::DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               front_busy,
  input  logic [1:0]         action,
  input  logic [15:0]        sine_value,
  input  logic [15:0]        cosine_value,
  input  logic [15:0]        distance_value,
  input  logic [15:0]        cell_weight,
  input  logic [7:0]         read_row,
  input  logic [7:0]         read_col,
  output logic               push,
  input  logic               q_full,
  output hlb_pkg::cmd_t      push_cmd
);
  import hlb_pkg::*;

  front_state_t state, state_next;
  logic       accept, load_b, div_done;
  cmd_kind_t  kind_in;
  logic       col_in;
  logic [15:0] s_mag, c_mag, r_mag;

  cmd_kind_t  kind;
  logic       by_col;
  logic [15:0] weight, den_mag;
  logic [7:0] rrow, rcol;
  logic       neg_a, neg_b;
  logic [15:0] rho_mag;
  logic signed [47:0] slope, offset;

  logic [16:0] rem;
  logic [DVD_W-1:0] dvd, quo;
  logic [5:0] cnt;
  logic [16:0] trial;
  logic       ge;
  logic [47:0] quo_ext;

  assign s_mag = sine_value[15] ? 16'(-sine_value) : sine_value;
  assign c_mag = cosine_value[15] ? 16'(-cosine_value) : cosine_value;
  assign r_mag = distance_value[15] ? 16'(-distance_value) : distance_value;
  assign col_in = (s_mag >= SIN_LIMIT);

  always_comb begin
    kind_in = CMD_NONE;
    case (action)
      ACT_PROJECT: begin
        if (cell_weight != 16'd0 && (col_in || cosine_value != 16'd0)) begin
          kind_in = CMD_PROJ;
        end
      end
      ACT_READ: begin
        if ({5'd0, read_row} < 13'(MAX_ROWS) && {5'd0, read_col} < 13'(MAX_COLS)) begin
          kind_in = CMD_READ;
        end
      end
      ACT_CLEAR: kind_in = CMD_CLEAR;
      default: kind_in = CMD_NONE;
    endcase
  end

  assign front_busy = (state != F_IDLE);
  assign accept     = start && (state == F_IDLE);
  assign div_done   = (cnt == DIV_STEPS);
  assign trial      = {rem[15:0], dvd[DVD_W-1]};
  assign ge         = (trial >= {1'b0, den_mag});
  assign quo_ext    = {5'd0, quo};

  always_comb begin
    state_next = state;
    load_b     = 1'b0;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (kind_in == CMD_PROJ) ? F_DIV_A : F_PUSH;
        end
      end
      F_DIV_A: begin
        if (div_done) begin
          load_b     = 1'b1;
          state_next = F_DIV_B;
        end
      end
      F_DIV_B: begin
        if (div_done) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind    <= kind_in;
      by_col  <= col_in;
      weight  <= cell_weight;
      rrow    <= read_row;
      rcol    <= read_col;
      rho_mag <= r_mag;
      slope   <= '0;
      offset  <= '0;
      den_mag <= col_in ? s_mag : c_mag;
      if (col_in) begin
        neg_a <= (cosine_value != 16'd0) && (cosine_value[15] == sine_value[15]);
        neg_b <= distance_value[15] ^ sine_value[15];
        dvd   <= {11'd0, c_mag, 16'd0};
      end else begin
        neg_a <= (sine_value != 16'd0) && (sine_value[15] == cosine_value[15]);
        neg_b <= distance_value[15] ^ cosine_value[15];
        dvd   <= {11'd0, s_mag, 16'd0};
      end
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (load_b) begin
      slope <= neg_a ? -$signed(quo_ext) : $signed(quo_ext);
      dvd   <= {rho_mag, 27'd0};
      rem   <= '0;
      quo   <= '0;
      cnt   <= '0;
    end else if ((state == F_DIV_A || state == F_DIV_B) && !div_done) begin
      rem <= ge ? (trial - {1'b0, den_mag}) : trial;
      quo <= {quo[DVD_W-2:0], ge};
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      cnt <= cnt + 6'd1;
    end else if (state == F_DIV_B && div_done) begin
      offset <= neg_b ? -$signed(quo_ext) : $signed(quo_ext);
    end
  end

  always_comb begin
    push_cmd.kind   = kind;
    push_cmd.by_col = by_col;
    push_cmd.slope  = slope;
    push_cmd.offset = offset;
    push_cmd.weight = weight;
    push_cmd.rrow   = rrow;
    push_cmd.rcol   = rcol;
  end

endmodule

// ===== hdl/hlb_queue.sv =====
module hlb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hlb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output hlb_pkg::cmd_t head
);
  import hlb_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/hlb_back.sv =====
module hlb_back #(
  parameter int MAX_ROWS = hlb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hlb_pkg::DEF_MAX_COLS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [8:0]    rows_in_use,
  input  logic [8:0]    cols_in_use,
  input  logic          empty,
  input  hlb_pkg::cmd_t head,
  output logic          pop,
  output logic          init_busy,
  output logic          done,
  output logic [15:0]   pixel_value,
  output logic [8:0]    pixels_hit
);
  import hlb_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  back_state_t state, state_next;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr, clr_addr;
  logic [15:0] wr_data;

  logic [DIM_W-1:0] nrow, ncol, steps, lim, k, hits, coord;
  logic signed [ACC_W-1:0] v, slope;
  logic [15:0] weight;
  logic        by_col, in_range, last_step, clr_last;
  logic        pend_valid;
  logic [AW-1:0] pend_addr, walk_addr, read_addr;

  assign nrow = ({4'd0, rows_in_use} > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                          : {4'd0, rows_in_use};
  assign ncol = ({4'd0, cols_in_use} > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                          : {4'd0, cols_in_use};

  assign in_range  = (v > -48'sd65536) &&
                     (v[ACC_W-1] ? (lim != '0) : (v[47:16] < 32'(lim)));
  assign coord     = v[ACC_W-1] ? '0 : v[16 +: DIM_W];
  assign walk_addr = by_col ? AW'(AW'(coord) * AW'(MAX_COLS) + AW'(k))
                            : AW'(AW'(k) * AW'(MAX_COLS) + AW'(coord));
  assign read_addr = AW'(AW'(head.rrow) * AW'(MAX_COLS) + AW'(head.rcol));
  assign last_step = (k + DIM_W'(1) == steps);
  assign clr_last  = (clr_addr == AW'(DEPTH - 1));
  assign init_busy = (state == B_INIT);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = walk_addr;
    wr_en      = pend_valid;
    wr_addr    = pend_addr;
    wr_data    = 16'(rd_data + weight);
    case (state)
      B_INIT, B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_last) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_PROJ: begin
              if ((head.by_col ? ncol : nrow) != '0) begin
                state_next = B_WALK;
              end
            end
            CMD_READ: begin
              rd_en      = 1'b1;
              rd_addr    = read_addr;
              state_next = B_READ;
            end
            CMD_CLEAR: state_next = B_CLEAR;
            default:   state_next = B_IDLE;
          endcase
        end
      end
      B_WALK: begin
        rd_en = in_range;
        if (last_step) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: state_next = B_IDLE;
      B_READ:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_INIT;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == B_WALK) && in_range;
      done       <= 1'b0;
      if (state == B_INIT || state == B_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
        done     <= clr_last && (state == B_CLEAR);
      end
      if (state == B_IDLE && !empty) begin
        done <= (head.kind == CMD_NONE) ||
                (head.kind == CMD_PROJ && (head.by_col ? ncol : nrow) == '0);
      end
      if (state == B_DRAIN || state == B_READ) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= walk_addr;
    if (state == B_IDLE && !empty) begin
      by_col      <= head.by_col;
      slope       <= head.slope;
      v           <= head.offset + 48'sd32768;
      weight      <= head.weight;
      k           <= '0;
      hits        <= '0;
      steps       <= head.by_col ? ncol : nrow;
      lim         <= head.by_col ? nrow : ncol;
      pixel_value <= '0;
      pixels_hit  <= '0;
    end
    if (state == B_WALK) begin
      v <= v + slope;
      k <= k + DIM_W'(1);
      if (in_range) begin
        hits <= hits + DIM_W'(1);
      end
    end
    if (state == B_DRAIN) begin
      pixels_hit <= hits[8:0];
    end
    if (state == B_READ) begin
      pixel_value <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/hough_line_backprojector_top.sv =====
// Hough line back-projector: accumulates cell lines into an image store.
// Command channel: an item is taken when start is high and busy is low.
// action 0 projects one cell line (sin, cos Q1.15, rho Q11.4, weight),
// action 1 reads one pixel, action 2 clears the image.
// Every item gives one result, shown for one cycle with done high:
// pixel_value and pixels_hit. The receiver cannot stall; done is a strobe.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 rows_in_use, 1 cols_in_use,
// to be written by the user only while the block is idle; not enforced here.
// A project item first runs the serial divider (two quotients of 43 bits),
// then walks one line position per clock through the image memory
// read-modify-write port; the number of steps is the columns or rows in use.
// The divider of the next item overlaps the walk of the current one via a
// 2-entry queue. A clear zeroes all MAX_ROWS*MAX_COLS cells of the image.
// After reset, busy stays high for a clearing pass while all MAX_ROWS*MAX_COLS
// cells of the image memory (65536 at default size) are zeroed.
module hough_line_backprojector_top #(
  parameter int MAX_ROWS = hlb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hlb_pkg::DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] sine_value,
  input  logic [15:0] cosine_value,
  input  logic [15:0] distance_value,
  input  logic [15:0] cell_weight,
  input  logic [7:0]  read_row,
  input  logic [7:0]  read_col,
  output logic        done,
  output logic [15:0] pixel_value,
  output logic [8:0]  pixels_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import hlb_pkg::*;

  logic [8:0] rows_in_use, cols_in_use;
  logic       front_busy, init_busy;
  logic       push, q_full, pop, q_empty;
  cmd_t       push_cmd, head;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy | init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) begin
        rows_in_use <= cfg_data;
      end else if (cfg_index == REG_COLS) begin
        cols_in_use <= cfg_data;
      end
    end
  end

  hlb_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start && !init_busy),
    .front_busy     (front_busy),
    .action         (action),
    .sine_value     (sine_value),
    .cosine_value   (cosine_value),
    .distance_value (distance_value),
    .cell_weight    (cell_weight),
    .read_row       (read_row),
    .read_col       (read_col),
    .push           (push),
    .q_full         (q_full),
    .push_cmd       (push_cmd)
  );

  hlb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  hlb_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .init_busy   (init_busy),
    .done        (done),
    .pixel_value (pixel_value),
    .pixels_hit  (pixels_hit)
  );

endmodule

// ===== hdl/hlb_checker.sv =====
`include "hough_line_backprojector_top_macros.svh"

module hlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] pixel_value,
  input logic [8:0]  pixels_hit
);

  `HLB_ASSERT_ALWAYS(a_busy_after_reset, rst, busy)
  `HLB_ASSERT_ALWAYS(a_no_done_after_reset, rst, !done)
  `HLB_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy)
  `HLB_ASSERT_NOW(a_one_field_nonzero, done, pixel_value == 16'd0 || pixels_hit == 9'd0)

endmodule

bind hough_line_backprojector_top hlb_checker u_hlb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pixel_value (pixel_value),
  .pixels_hit  (pixels_hit)
);
